[hdl/virtio_common_config_regs_core_assert.svh]
`ifndef VIRTIO_COMMON_CONFIG_REGS_CORE_ASSERT_SVH
`define VIRTIO_COMMON_CONFIG_REGS_CORE_ASSERT_SVH

// clocked assertion, off while in reset
`ifndef NO_ASSERTIONS
`define VCCR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`else
`define VCCR_ASSERT(name, prop, msg)
`endif

// clocked assertion, also checked during reset
`ifndef NO_ASSERTIONS
`define VCCR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define VCCR_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

[hdl/vccr_pkg.sv]
package vccr_pkg;

  localparam int unsigned DefNumQueues = 4;
  localparam logic [63:0] DefDevFeatures = 64'h0000_0001_0000_0000;
  localparam logic [15:0] DefMaxQueueSize = 16'd256;

  typedef enum logic [0:0] {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_DEV_FEATURES = 1'b0,
    CFG_MAX_QSIZE    = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    OFF_FEAT_SEL   = 6'h00,
    OFF_DEV_FEAT   = 6'h04,
    OFF_DRV_SEL    = 6'h08,
    OFF_DRV_FEAT   = 6'h0C,
    OFF_STATUS     = 6'h14,
    OFF_QSEL       = 6'h16,
    OFF_QSIZE      = 6'h18,
    OFF_QENABLE    = 6'h1C,
    OFF_QNOTIFY    = 6'h1E,
    OFF_QDESC_LO   = 6'h20,
    OFF_QDESC_HI   = 6'h24,
    OFF_QAVAIL_LO  = 6'h28,
    OFF_QAVAIL_HI  = 6'h2C,
    OFF_QUSED_LO   = 6'h30,
    OFF_QUSED_HI   = 6'h34
  } offset_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [5:0]  offset;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        hit;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic wr_size;
    logic wr_enable;
    logic wr_desc;
    logic wr_avail;
    logic wr_used;
    logic hi;
  } q_cmd_t;

  typedef struct packed {
    logic [15:0] size;
    logic        enable;
    logic [63:0] desc;
    logic [63:0] avail;
    logic [63:0] used;
  } q_rd_t;

endpackage

[hdl/vccr_queue_file.sv]
module vccr_queue_file #(
  parameter int unsigned NUM_QUEUES = vccr_pkg::DefNumQueues,
  parameter int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  vccr_pkg::q_cmd_t cmd_i,
  input  logic [QW-1:0]    idx_i,
  input  logic [31:0]      wdata_i,
  input  logic [15:0]      max_size_i,
  output vccr_pkg::q_rd_t  rd_o
);

  logic [15:0] size_q  [NUM_QUEUES];
  logic        en_q    [NUM_QUEUES];
  logic [63:0] desc_q  [NUM_QUEUES];
  logic [63:0] avail_q [NUM_QUEUES];
  logic [63:0] used_q  [NUM_QUEUES];

  logic [15:0] size_sat;

  // size writes saturate at the maximum
  assign size_sat = (wdata_i[15:0] > max_size_i) ? max_size_i : wdata_i[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        size_q[q]  <= vccr_pkg::DefMaxQueueSize;
        en_q[q]    <= 1'b0;
        desc_q[q]  <= '0;
        avail_q[q] <= '0;
        used_q[q]  <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        size_q[q]  <= max_size_i;
        en_q[q]    <= 1'b0;
        desc_q[q]  <= '0;
        avail_q[q] <= '0;
        used_q[q]  <= '0;
      end
    end else begin
      for (int q = 0; q < NUM_QUEUES; q++) begin
        if (idx_i == QW'(q)) begin
          if (cmd_i.wr_size) begin
            size_q[q] <= size_sat;
          end
          if (cmd_i.wr_enable) begin
            en_q[q] <= wdata_i[0];
          end
          if (cmd_i.wr_desc) begin
            if (cmd_i.hi) desc_q[q][63:32] <= wdata_i;
            else desc_q[q][31:0] <= wdata_i;
          end
          if (cmd_i.wr_avail) begin
            if (cmd_i.hi) avail_q[q][63:32] <= wdata_i;
            else avail_q[q][31:0] <= wdata_i;
          end
          if (cmd_i.wr_used) begin
            if (cmd_i.hi) used_q[q][63:32] <= wdata_i;
            else used_q[q][31:0] <= wdata_i;
          end
        end
      end
    end
  end

  assign rd_o.size   = size_q[idx_i];
  assign rd_o.enable = en_q[idx_i];
  assign rd_o.desc   = desc_q[idx_i];
  assign rd_o.avail  = avail_q[idx_i];
  assign rd_o.used   = used_q[idx_i];

endmodule

[hdl/virtio_common_config_regs_core.sv]
// channel   | signals                               | accepted when
// request   | in_valid_i, in_stall_o, in_item_i     | in_valid_i && !in_stall_o
// response  | out_valid_o, out_stall_i, out_item_o  | out_valid_o && !out_stall_i
// config    | cfg_we_i, cfg_idx_i, cfg_wdata_i      | cfg_we_i
//
// one item per cycle when not stalled; item -> input register -> result register
// the whole access is decoded and applied combinationally between the two registers
// reset clears all but pipe_q, rsp_q; queue sizes back at 256, features at version one
// a stalled result holds the result register; one more item waits in the input register

`include "virtio_common_config_regs_core_assert.svh"

module virtio_common_config_regs_core #(
  parameter int unsigned NUM_QUEUES = vccr_pkg::DefNumQueues
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  vccr_pkg::req_t in_item_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output vccr_pkg::rsp_t out_item_o,
  input  logic           cfg_we_i,
  input  logic [0:0]     cfg_idx_i,
  input  logic [63:0]    cfg_wdata_i
);

  localparam int unsigned QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  logic           pipe_valid_q;
  vccr_pkg::req_t pipe_q;
  logic           out_valid_q;
  vccr_pkg::rsp_t rsp_q, rsp_d;

  logic [63:0] dev_feat_q;
  logic [15:0] max_qsize_q;
  logic [31:0] feat_sel_q, feat_sel_d;
  logic [31:0] drv_sel_q, drv_sel_d;
  logic [63:0] acc_feat_q, acc_feat_d;
  logic [7:0]  status_q, status_d;
  logic [15:0] qsel_q, qsel_d;

  logic             fire, accept_in, wr, present;
  logic [31:0]      wd, rd;
  logic             hit;
  logic [QW-1:0]    qidx;
  vccr_pkg::q_cmd_t qcmd;
  vccr_pkg::q_rd_t  qrd;

  assign fire       = pipe_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = pipe_valid_q && !fire;
  assign accept_in  = in_valid_i && !in_stall_o;

  assign wr      = (pipe_q.cmd == vccr_pkg::CMD_WRITE);
  assign wd      = pipe_q.write_data;
  assign present = (qsel_q < 16'(NUM_QUEUES));
  assign qidx    = qsel_q[QW-1:0];

  always_comb begin
    rd         = '0;
    hit        = 1'b1;
    feat_sel_d = feat_sel_q;
    drv_sel_d  = drv_sel_q;
    acc_feat_d = acc_feat_q;
    status_d   = status_q;
    qsel_d     = qsel_q;
    qcmd       = '0;
    qcmd.hi    = pipe_q.offset[2];
    unique case (pipe_q.offset)
      vccr_pkg::OFF_FEAT_SEL: begin
        if (wr) feat_sel_d = wd;
        else rd = feat_sel_q;
      end
      vccr_pkg::OFF_DEV_FEAT: begin
        if (feat_sel_q == 32'd0) rd = dev_feat_q[31:0];
        else if (feat_sel_q == 32'd1) rd = dev_feat_q[63:32];
      end
      vccr_pkg::OFF_DRV_SEL: begin
        if (wr) drv_sel_d = wd;
        else rd = drv_sel_q;
      end
      vccr_pkg::OFF_DRV_FEAT: begin
        if (drv_sel_q == 32'd0) begin
          if (wr) acc_feat_d[31:0] = wd;
          else rd = acc_feat_q[31:0];
        end else if (drv_sel_q == 32'd1) begin
          if (wr) acc_feat_d[63:32] = wd;
          else rd = acc_feat_q[63:32];
        end
      end
      vccr_pkg::OFF_STATUS: begin
        if (wr) begin
          status_d = wd[7:0];
          // device reset
          if (wd[7:0] == 8'd0) begin
            acc_feat_d = '0;
            qcmd.clear = fire;
          end
        end else begin
          rd = {24'd0, status_q};
        end
      end
      vccr_pkg::OFF_QSEL: begin
        if (wr) qsel_d = wd[15:0];
        else rd = {16'd0, qsel_q};
      end
      vccr_pkg::OFF_QSIZE: begin
        qcmd.wr_size = fire && wr && present;
        if (present) rd = {16'd0, qrd.size};
      end
      vccr_pkg::OFF_QENABLE: begin
        qcmd.wr_enable = fire && wr && present;
        if (present) rd = {31'd0, qrd.enable};
      end
      vccr_pkg::OFF_QNOTIFY: begin
        if (present) rd = {16'd0, qsel_q};
      end
      vccr_pkg::OFF_QDESC_LO, vccr_pkg::OFF_QDESC_HI: begin
        qcmd.wr_desc = fire && wr && present;
        if (present) rd = pipe_q.offset[2] ? qrd.desc[63:32] : qrd.desc[31:0];
      end
      vccr_pkg::OFF_QAVAIL_LO, vccr_pkg::OFF_QAVAIL_HI: begin
        qcmd.wr_avail = fire && wr && present;
        if (present) rd = pipe_q.offset[2] ? qrd.avail[63:32] : qrd.avail[31:0];
      end
      vccr_pkg::OFF_QUSED_LO, vccr_pkg::OFF_QUSED_HI: begin
        qcmd.wr_used = fire && wr && present;
        if (present) rd = pipe_q.offset[2] ? qrd.used[63:32] : qrd.used[31:0];
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    rsp_d.read_data = wr ? 32'd0 : rd;
    rsp_d.hit       = hit;
  end

  vccr_queue_file #(
    .NUM_QUEUES(NUM_QUEUES),
    .QW        (QW)
  ) u_queue_file (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (qcmd),
    .idx_i     (qidx),
    .wdata_i   (wd),
    .max_size_i(max_qsize_q),
    .rd_o      (qrd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_feat_q  <= vccr_pkg::DefDevFeatures;
      max_qsize_q <= vccr_pkg::DefMaxQueueSize;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vccr_pkg::CFG_DEV_FEATURES: dev_feat_q  <= cfg_wdata_i;
        vccr_pkg::CFG_MAX_QSIZE:    max_qsize_q <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_sel_q <= '0;
      drv_sel_q  <= '0;
      acc_feat_q <= '0;
      status_q   <= '0;
      qsel_q     <= '0;
    end else if (fire) begin
      feat_sel_q <= feat_sel_d;
      drv_sel_q  <= drv_sel_d;
      acc_feat_q <= acc_feat_d;
      status_q   <= status_d;
      qsel_q     <= qsel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept_in) pipe_valid_q <= 1'b1;
      else if (fire) pipe_valid_q <= 1'b0;
      if (fire) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) pipe_q <= in_item_i;
    if (fire) rsp_q <= rsp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = rsp_q;

  `VCCR_ASSERT_ALWAYS(a_stall_needs_item,
    in_stall_o |-> pipe_valid_q,
    "stall without held item")
  `VCCR_ASSERT(a_write_reads_zero,
    fire && wr |=> rsp_q.read_data == 32'd0,
    "write returned data")
  `VCCR_ASSERT(a_status_reset,
    fire && wr && pipe_q.offset == vccr_pkg::OFF_STATUS && wd[7:0] == 8'd0
      |=> acc_feat_q == 64'd0 && status_q == 8'd0,
    "device reset did not clear")
  `VCCR_ASSERT(a_absent_queue,
    fire && !wr && !present && pipe_q.offset == vccr_pkg::OFF_QSIZE
      |=> rsp_q.read_data == 32'd0 && rsp_q.hit,
    "absent queue size not zero")

endmodule
